// ===== rtl/positional_array_list_engine_top_assert.svh =====
// Assertion macros for the positional array list engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pale_pkg.sv =====
package pale_pkg;

  // Default storage geometry.
  localparam int DEPTH_DEF = 1024;
  localparam int WIDTH_DEF = 32;

  // Fixed field widths of the beats.
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 10;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LOCATE = 2'd2,
    FN_GET    = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } stat_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_LOC_SCAN,
    S_GET_SCAN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  init_ins;
    logic  init_del;
    logic  init_loc;
    logic  init_get;
    logic  issue;
    logic  wr_up;
    logic  wr_down;
    logic  wr_val;
    logic  set_status;
    stat_t status;
    logic  cap_idx;
    logic  cap_rdv;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  full;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  rem_zero;
    logic  pend;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

// ===== rtl/pale_ctrl.sv =====
module pale_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pale_pkg::sts_t   sts,
  output pale_pkg::cmd_t   cmd
);

  pale_pkg::state_t state_r;
  pale_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pale_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pale_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pale_pkg::S_CHECK;
      end
      pale_pkg::S_CHECK: begin
        case (sts.func)
          pale_pkg::FN_INSERT: begin
            if (sts.full || sts.pos_gt_cnt) state_nxt = pale_pkg::S_DONE;
            else state_nxt = pale_pkg::S_INS_SHIFT;
          end
          pale_pkg::FN_DELETE: begin
            if (sts.pos_ge_cnt) state_nxt = pale_pkg::S_DONE;
            else state_nxt = pale_pkg::S_DEL_SHIFT;
          end
          pale_pkg::FN_LOCATE: begin
            state_nxt = pale_pkg::S_LOC_SCAN;
          end
          default: begin
            if (sts.pos_ge_cnt) state_nxt = pale_pkg::S_DONE;
            else state_nxt = pale_pkg::S_GET_SCAN;
          end
        endcase
      end
      pale_pkg::S_INS_SHIFT: begin
        if (sts.rem_zero && !sts.pend) state_nxt = pale_pkg::S_INS_PUT;
      end
      pale_pkg::S_INS_PUT: begin
        state_nxt = pale_pkg::S_DONE;
      end
      pale_pkg::S_DEL_SHIFT: begin
        if (sts.rem_zero && !sts.pend) state_nxt = pale_pkg::S_DONE;
      end
      pale_pkg::S_LOC_SCAN: begin
        if ((sts.pend && sts.match) || (sts.rem_zero && !sts.pend)) begin
          state_nxt = pale_pkg::S_DONE;
        end
      end
      pale_pkg::S_GET_SCAN: begin
        if (sts.pend) state_nxt = pale_pkg::S_DONE;
      end
      pale_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = pale_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pale_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      pale_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pale_pkg::S_CHECK: begin
        case (sts.func)
          pale_pkg::FN_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = pale_pkg::ST_FULL;
            end else if (sts.pos_gt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = pale_pkg::ST_BAD_POS;
            end else begin
              cmd.init_ins = 1'b1;
            end
          end
          pale_pkg::FN_DELETE: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = pale_pkg::ST_BAD_POS;
            end else begin
              cmd.init_del = 1'b1;
            end
          end
          pale_pkg::FN_LOCATE: begin
            // Assume a miss until a matching entry shows up.
            cmd.init_loc   = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = pale_pkg::ST_NOT_FOUND;
          end
          default: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = pale_pkg::ST_BAD_POS;
            end else begin
              cmd.init_get = 1'b1;
            end
          end
        endcase
      end
      pale_pkg::S_INS_SHIFT: begin
        // Read one entry per cycle and write it one slot higher in the cycle after.
        cmd.issue = !sts.rem_zero;
        cmd.wr_up = sts.pend;
      end
      pale_pkg::S_INS_PUT: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      pale_pkg::S_DEL_SHIFT: begin
        // Read one entry per cycle and write it one slot lower in the cycle after.
        cmd.issue   = !sts.rem_zero;
        cmd.wr_down = sts.pend;
        cmd.cnt_dec = sts.rem_zero && !sts.pend;
      end
      pale_pkg::S_LOC_SCAN: begin
        cmd.issue = !sts.rem_zero && !(sts.pend && sts.match);
        if (sts.pend && sts.match) begin
          cmd.set_status = 1'b1;
          cmd.status     = pale_pkg::ST_OK;
          cmd.cap_idx    = 1'b1;
        end
      end
      pale_pkg::S_GET_SCAN: begin
        cmd.issue   = !sts.rem_zero;
        cmd.cap_rdv = sts.pend;
      end
      pale_pkg::S_DONE: begin
        cmd.push = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/pale_dp.sv =====
module pale_dp #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF,
  parameter int WIDTH = pale_pkg::WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [pale_pkg::FUNC_W-1:0]    in_func,
  input  logic        [pale_pkg::POS_W-1:0]     in_position,
  input  logic signed [pale_pkg::VAL_W-1:0]     in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [pale_pkg::STAT_W-1:0]    out_status,
  output logic        [pale_pkg::POS_W-1:0]     out_found_index,
  output logic signed [pale_pkg::VAL_W-1:0]     out_read_value,
  output logic        [pale_pkg::CNT_OUT_W-1:0] out_count_after,
  input  pale_pkg::cmd_t                      cmd,
  output pale_pkg::sts_t                      sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > pale_pkg::CNT_OUT_W) ? CW : pale_pkg::CNT_OUT_W;

  // List storage.
  logic [WIDTH-1:0] list_mem_r [DEPTH];

  // Latched operation.
  pale_pkg::func_t            func_r;
  logic [pale_pkg::POS_W-1:0] pos_r;
  logic [WIDTH-1:0]           val_r;

  // Element count and walk state.
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    ptr_r;
  logic             dir_up_r;
  logic [CW-1:0]    rem_r;
  logic             pend_r;
  logic [AW-1:0]    paddr_r;
  logic [WIDTH-1:0] rd_data_r;

  // Result scratch.
  pale_pkg::stat_t  st_r;
  logic [AW-1:0]    idx_r;
  logic [WIDTH-1:0] rdv_r;

  // Output register.
  logic                           out_valid_r;
  pale_pkg::stat_t                out_status_r;
  logic [pale_pkg::POS_W-1:0]     out_idx_r;
  logic [pale_pkg::VAL_W-1:0]     out_rdv_r;
  logic [pale_pkg::CNT_OUT_W-1:0] out_cnt_r;

  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    idx_x;
  logic [63:0]      val_x;
  logic [63:0]      rdv_x;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;

  // Widened views for compares and output fields.
  assign pos_x = XW'(pos_r);
  assign cnt_x = XW'(cnt_r);
  assign idx_x = XW'(idx_r);
  assign val_x = {32'd0, in_value};

  always_comb begin
    rdv_x = '0;
    rdv_x[WIDTH-1:0] = rdv_r;
  end

  // Status toward the controller.
  always_comb begin
    sts.func       = func_r;
    sts.full       = (cnt_x == XW'(DEPTH));
    sts.pos_gt_cnt = (pos_x > cnt_x);
    sts.pos_ge_cnt = (pos_x >= cnt_x);
    sts.rem_zero   = (rem_r == '0);
    sts.pend       = pend_r;
    sts.match      = (rd_data_r == val_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Operation latch on an accepted input beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= pale_pkg::func_t'(in_func);
      pos_r  <= in_position;
      val_r  <= val_x[WIDTH-1:0];
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Walk pointer and remaining-read counter.
  always_ff @(posedge clk) begin
    if (cmd.init_ins) begin
      ptr_r    <= AW'(cnt_x - XW'(1));
      rem_r    <= CW'(cnt_x - pos_x);
      dir_up_r <= 1'b0;
    end else if (cmd.init_del) begin
      ptr_r    <= AW'(pos_x + XW'(1));
      rem_r    <= CW'(cnt_x - pos_x - XW'(1));
      dir_up_r <= 1'b1;
    end else if (cmd.init_loc) begin
      ptr_r    <= '0;
      rem_r    <= cnt_r;
      dir_up_r <= 1'b1;
    end else if (cmd.init_get) begin
      ptr_r    <= pos_x[AW-1:0];
      rem_r    <= CW'(1);
      dir_up_r <= 1'b1;
    end else if (cmd.issue) begin
      ptr_r <= dir_up_r ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
      rem_r <= rem_r - CW'(1);
    end
  end

  // Read tracking: pend_r marks fresh data in rd_data_r from paddr_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) paddr_r <= ptr_r;
  end

  // Write port selection.
  always_comb begin
    wr_en   = cmd.wr_up || cmd.wr_down || cmd.wr_val;
    wr_data = cmd.wr_val ? val_r : rd_data_r;
    if (cmd.wr_up) begin
      wr_addr = paddr_r + AW'(1);
    end else if (cmd.wr_down) begin
      wr_addr = paddr_r - AW'(1);
    end else begin
      wr_addr = pos_x[AW-1:0];
    end
  end

  // Memory: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.issue) rd_data_r <= list_mem_r[ptr_r];
    if (wr_en) list_mem_r[wr_addr] <= wr_data;
  end

  // Result scratch registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r  <= pale_pkg::ST_OK;
      idx_r <= '0;
      rdv_r <= '0;
    end else begin
      if (cmd.set_status) st_r <= cmd.status;
      if (cmd.cap_idx) idx_r <= paddr_r;
      if (cmd.cap_rdv) rdv_r <= rd_data_r;
    end
  end

  // Output register, free to refill in the cycle its beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status_r <= st_r;
      out_idx_r    <= idx_x[pale_pkg::POS_W-1:0];
      out_rdv_r    <= rdv_x[pale_pkg::VAL_W-1:0];
      out_cnt_r    <= cnt_x[pale_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_read_value  = out_rdv_r;
  assign out_count_after = out_cnt_r;

endmodule

// ===== rtl/positional_array_list_engine_top.sv =====
// The time from an accepted input beat to its result beat depends on the operation:
// insert and delete grow with (count - position), locate grows with the hit index,
// or with the count on a miss; result stalls add to it. One item is in work at a time
// and the next input beat is taken in the cycle after the result is pushed.
// Reset clears the element count (empty list) and the handshake state, not the store.
`include "positional_array_list_engine_top_assert.svh"

module positional_array_list_engine_top #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF,
  parameter int WIDTH = pale_pkg::WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [pale_pkg::FUNC_W-1:0]    in_func,
  input  logic        [pale_pkg::POS_W-1:0]     in_position,
  input  logic signed [pale_pkg::VAL_W-1:0]     in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [pale_pkg::STAT_W-1:0]    out_status,
  output logic        [pale_pkg::POS_W-1:0]     out_found_index,
  output logic signed [pale_pkg::VAL_W-1:0]     out_read_value,
  output logic        [pale_pkg::CNT_OUT_W-1:0] out_count_after
);

  pale_pkg::cmd_t cmd;
  pale_pkg::sts_t sts;
  logic [2:0]     wr_sel;

  // Sequencer.
  pale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, counters and result registers.
  pale_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after),
    .cmd             (cmd),
    .sts             (sts)
  );

  // Write sources into the store must never collide.
  assign wr_sel = {cmd.wr_up, cmd.wr_down, cmd.wr_val};

  `PALE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input accepted while an item is still in work")
  `PALE_ASSERT_NOW(a_push_needs_room, cmd.push, sts.out_free,
    "result pushed over an untaken result beat")
  `PALE_ASSERT_NOW(a_single_writer, |wr_sel, $onehot0(wr_sel),
    "two write sources active in one cycle")
  `PALE_ASSERT_NOW(a_issue_in_range, cmd.issue, !sts.rem_zero,
    "memory read issued past the end of the walk")

endmodule

// ===== test/tb_positional_array_list_engine_top.sv =====
module tb_positional_array_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH     = pale_pkg::DEPTH_DEF;
  localparam int GROW_LEN       = 150;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int MAX_PRINTED    = 100;
  localparam logic signed [pale_pkg::VAL_W-1:0] TAIL_MARKER = 32'sh1357_9bdf;

  // One operation beat and the answer it should produce.
  typedef struct {
    pale_pkg::func_t                   func;
    logic [pale_pkg::POS_W-1:0]        position;
    logic signed [pale_pkg::VAL_W-1:0] value;
  } list_op_t;

  typedef struct {
    pale_pkg::stat_t                   status;
    logic [pale_pkg::POS_W-1:0]        found_index;
    logic signed [pale_pkg::VAL_W-1:0] read_value;
    logic [pale_pkg::CNT_OUT_W-1:0]    count_after;
  } list_answer_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [pale_pkg::FUNC_W-1:0]         in_func = '0;
  logic [pale_pkg::POS_W-1:0]          in_position = '0;
  logic signed [pale_pkg::VAL_W-1:0]   in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [pale_pkg::STAT_W-1:0]         out_status;
  logic [pale_pkg::POS_W-1:0]          out_found_index;
  logic signed [pale_pkg::VAL_W-1:0]   out_read_value;
  logic [pale_pkg::CNT_OUT_W-1:0]      out_count_after;

  // Shadow copy of the list, updated as each operation beat is accepted.
  logic signed [pale_pkg::VAL_W-1:0] shadow_words [LIST_DEPTH];
  int                                shadow_len = 0;
  int                                peak_len = 0;

  list_op_t     pending_ops [$];
  list_answer_t expected_answers [$];
  list_op_t     next_op;
  list_op_t     taken_op;
  list_answer_t fresh_answer;
  list_answer_t head_answer;

  int  gen_len = 0;
  int  total_ops = 0;
  int  ops_accepted = 0;
  int  answers_checked = 0;
  int  failures = 0;
  int  idle_cycles = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  in_taken = 1'b0;

  positional_array_list_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_count_after (out_count_after)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (failures < MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    failures++;
  endtask

  // Apply one operation to the shadow list and work out its answer.
  task automatic apply_list_op(input list_op_t op, output list_answer_t ans);
    int j;
    ans.status      = pale_pkg::ST_OK;
    ans.found_index = '0;
    ans.read_value  = '0;
    case (op.func)
      pale_pkg::FN_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          ans.status = pale_pkg::ST_FULL;
        end else if (int'(op.position) > shadow_len) begin
          ans.status = pale_pkg::ST_BAD_POS;
        end else begin
          for (j = shadow_len; j > int'(op.position); j--) begin
            shadow_words[j] = shadow_words[j-1];
          end
          shadow_words[op.position] = op.value;
          shadow_len++;
        end
      end
      pale_pkg::FN_DELETE: begin
        if (int'(op.position) >= shadow_len) begin
          ans.status = pale_pkg::ST_BAD_POS;
        end else begin
          for (j = int'(op.position); j < shadow_len - 1; j++) begin
            shadow_words[j] = shadow_words[j+1];
          end
          shadow_len--;
        end
      end
      pale_pkg::FN_LOCATE: begin
        ans.status = pale_pkg::ST_NOT_FOUND;
        for (j = 0; j < shadow_len; j++) begin
          if (shadow_words[j] == op.value) begin
            ans.status      = pale_pkg::ST_OK;
            ans.found_index = j[pale_pkg::POS_W-1:0];
            break;
          end
        end
      end
      default: begin
        if (int'(op.position) >= shadow_len) begin
          ans.status = pale_pkg::ST_BAD_POS;
        end else begin
          ans.read_value = shadow_words[op.position];
        end
      end
    endcase
    ans.count_after = shadow_len[pale_pkg::CNT_OUT_W-1:0];
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  // Queue one operation and keep track of the list length it leaves behind.
  task automatic push_op(input pale_pkg::func_t f, input int pos,
                         input logic signed [pale_pkg::VAL_W-1:0] v);
    list_op_t op;
    op.func     = f;
    op.position = pos[pale_pkg::POS_W-1:0];
    op.value    = v;
    pending_ops.push_back(op);
    if (f == pale_pkg::FN_INSERT && gen_len < LIST_DEPTH && pos <= gen_len) begin
      gen_len++;
    end else if (f == pale_pkg::FN_DELETE && pos < gen_len) begin
      gen_len--;
    end
  endtask

  // A small set of values, so that locates hit and duplicates occur.
  function automatic logic signed [pale_pkg::VAL_W-1:0] pool_value();
    case ($urandom_range(7))
      0:       return 32'sh0000_0000;
      1:       return -32'sd1;
      2:       return 32'sh7fff_ffff;
      3:       return 32'sh8000_0000;
      4:       return 32'sh0000_0001;
      5:       return 32'sh5555_5555;
      6:       return 32'shaaaa_aaaa;
      default: return 32'sh0000_ffff;
    endcase
  endfunction

  function automatic logic signed [pale_pkg::VAL_W-1:0] pick_value(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return pool_value();
    return $urandom;
  endfunction

  // Mostly legal operations on a list kept short, with some raw noise.
  task automatic random_list_op();
    int r;
    int ins_w;
    int del_w;
    r = $urandom_range(99);
    if (r < 25) begin
      push_op(pale_pkg::func_t'($urandom_range(3)), $urandom_range(1023), $urandom);
    end else begin
      r     = $urandom_range(99);
      ins_w = (gen_len < 16) ? 45 : ((gen_len > 56) ? 15 : 30);
      del_w = (gen_len > 56) ? 45 : 25;
      if (gen_len == 0 || r < ins_w) begin
        push_op(pale_pkg::FN_INSERT, $urandom_range(gen_len), pick_value(40));
      end else if (r < ins_w + del_w) begin
        push_op(pale_pkg::FN_DELETE, $urandom_range(gen_len - 1), $urandom);
      end else if (r < ins_w + del_w + (100 - ins_w - del_w) / 2) begin
        push_op(pale_pkg::FN_LOCATE, $urandom_range(1023), pick_value(60));
      end else begin
        push_op(pale_pkg::FN_GET, $urandom_range(gen_len - 1), $urandom);
      end
    end
  endtask

  // Idle rates follow the progress of the run.
  always_comb begin
    if (ops_accepted < total_ops / 3) begin
      sender_idle_pct   = 15;
      receiver_idle_pct = 73;
    end else if (ops_accepted < (2 * total_ops) / 3) begin
      sender_idle_pct   = 73;
      receiver_idle_pct = 15;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  end

  // Driver: presents the next operation beat and the result-side ready.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_op     = pending_ops.pop_front();
          in_valid    <= 1'b1;
          in_func     <= next_op.func;
          in_position <= next_op.position;
          in_value    <= next_op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Monitor: predicts on accepted operation beats, checks accepted result beats.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      taken_op.func     = pale_pkg::func_t'(in_func);
      taken_op.position = in_position;
      taken_op.value    = in_value;
      apply_list_op(taken_op, fresh_answer);
      expected_answers.push_back(fresh_answer);
      ops_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result beat with no operation pending");
      end else begin
        head_answer = expected_answers.pop_front();
        if (out_status !== head_answer.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    answers_checked, out_status, head_answer.status));
        if (out_found_index !== head_answer.found_index)
          report_mismatch($sformatf("result %0d found_index %0d, expected %0d",
                                    answers_checked, out_found_index,
                                    head_answer.found_index));
        if (out_read_value !== head_answer.read_value)
          report_mismatch($sformatf("result %0d read_value %0h, expected %0h",
                                    answers_checked, out_read_value,
                                    head_answer.read_value));
        if (out_count_after !== head_answer.count_after)
          report_mismatch($sformatf("result %0d count_after %0d, expected %0d",
                                    answers_checked, out_count_after,
                                    head_answer.count_after));
        status_seen[head_answer.status]++;
      end
      answers_checked++;
    end
  end

  // Watchdog: cycles without any accepted beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;

    // Empty list: get, delete and locate must all fail, as must an insert past the end.
    push_op(pale_pkg::FN_GET,    0, 0);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    push_op(pale_pkg::FN_LOCATE, 0, 0);
    push_op(pale_pkg::FN_INSERT, 1, 32'sh7fff_ffff);
    // The only element can be deleted, leaving the list empty.
    push_op(pale_pkg::FN_INSERT, 0, 32'sh7fff_ffff);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    // Build a short list with the value extremes in the middle and -1 at the end.
    push_op(pale_pkg::FN_INSERT, 0, 32'sh8000_0000);
    push_op(pale_pkg::FN_INSERT, 1, -32'sd1);
    push_op(pale_pkg::FN_INSERT, 0, 32'sh0000_0000);
    push_op(pale_pkg::FN_INSERT, 1, 32'sh7fff_ffff);
    push_op(pale_pkg::FN_GET,    0, 0);
    push_op(pale_pkg::FN_GET,    1, 0);
    push_op(pale_pkg::FN_GET,    2, 0);
    push_op(pale_pkg::FN_GET,    3, 0);
    push_op(pale_pkg::FN_GET,    4, 0);
    push_op(pale_pkg::FN_GET,    1023, 0);
    push_op(pale_pkg::FN_LOCATE, 1023, -32'sd1);
    push_op(pale_pkg::FN_LOCATE, 0, 32'sh8000_0000);
    push_op(pale_pkg::FN_LOCATE, 0, 32'sh0000_0005);
    // A duplicate at the end: locate must still report the lowest index.
    push_op(pale_pkg::FN_INSERT, 4, -32'sd1);
    push_op(pale_pkg::FN_LOCATE, 0, -32'sd1);
    push_op(pale_pkg::FN_DELETE, 4, 0);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    push_op(pale_pkg::FN_INSERT, 1023, 32'sh0000_0001);
    push_op(pale_pkg::FN_DELETE, 1023, 0);

    repeat (180) random_list_op();

    // Grow a longer list by inserts near the front, so each one shifts many entries.
    while (gen_len < GROW_LEN) begin
      r = $urandom_range(99);
      if (r < 6 && gen_len > 0) begin
        push_op(pale_pkg::FN_GET, $urandom_range(gen_len - 1), $urandom);
      end else if (r < 9) begin
        push_op(pale_pkg::FN_LOCATE, $urandom_range(1023), pool_value());
      end else begin
        push_op(pale_pkg::FN_INSERT, $urandom_range((gen_len < 8) ? gen_len : 8),
                pick_value(30));
      end
    end
    push_op(pale_pkg::FN_INSERT, gen_len, TAIL_MARKER);
    push_op(pale_pkg::FN_LOCATE, 0, TAIL_MARKER);
    push_op(pale_pkg::FN_GET,    gen_len - 1, 0);
    push_op(pale_pkg::FN_INSERT, gen_len + 1, pool_value());
    push_op(pale_pkg::FN_LOCATE, 0, $urandom);

    // Shrink back to a short list from the front.
    while (gen_len > 10) begin
      if ($urandom_range(99) < 8) begin
        push_op(pale_pkg::FN_GET, $urandom_range(gen_len - 1), $urandom);
      end else begin
        push_op(pale_pkg::FN_DELETE, $urandom_range(3), $urandom);
      end
    end

    repeat (60) random_list_op();
    total_ops = pending_ops.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every operation to be accepted and answered.
    while ((pending_ops.size() != 0 || in_valid || expected_answers.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no beat accepted for %0d cycles, %0d results outstanding",
               idle_cycles, expected_answers.size());
      failures++;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    $display("Ran %0d operations, checked %0d results, peak list length %0d of %0d.",
             ops_accepted, answers_checked, peak_len, LIST_DEPTH);
    $display("Statuses seen: %0d ok, %0d full, %0d bad position, %0d not found.",
             status_seen[pale_pkg::ST_OK], status_seen[pale_pkg::ST_FULL],
             status_seen[pale_pkg::ST_BAD_POS], status_seen[pale_pkg::ST_NOT_FOUND]);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
